>>> src/psa_pkg.sv
// shared types and constants for the priority scheduler with aging
package psa_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int SLOT_W         = 4;
  localparam int SLOT_SPAN      = 1 << SLOT_W;
  localparam int PRIO_W         = 6;
  localparam int DYN_W          = 8;
  localparam int STAMP_W        = 16;

  localparam logic signed [DYN_W-1:0] DYN_FLOOR = {1'b1, {(DYN_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SETP   = 2'd2,
    CMD_SCHED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_USED    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_NO_TASK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REMOVE,
    OP_SETP,
    OP_AGE
  } cell_op_t;

  // broadcast from the control to every cell
  typedef struct packed {
    cell_op_t                 op;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRIO_W-1:0] prio;
    logic [STAMP_W-1:0]       stamp;
  } cell_ctrl_t;

  // running best candidate handed along the chain
  typedef struct packed {
    logic                    found;
    logic signed [DYN_W-1:0] dyn;
    logic [STAMP_W-1:0]      stamp;
  } cand_t;

endpackage

>>> src/psa_cell.sv
// one task slot of the chain: slot state plus a registered compare stage
module psa_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  psa_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]   best_idx,
  input  psa_pkg::cand_t     cand_in,
  input  logic [IDX_W-1:0]   idx_in,
  output psa_pkg::cand_t     cand_out,
  output logic [IDX_W-1:0]   idx_out,
  output logic               valid
);
  import psa_pkg::*;

  logic signed [PRIO_W-1:0] static_prio;
  logic signed [DYN_W-1:0]  dyn_prio;
  logic [STAMP_W-1:0]       insert_stamp;

  logic hit;
  logic is_best;
  logic own_better;

  // only the first slot span is reachable by the slot field
  assign hit     = (CELL_IDX < SLOT_SPAN) && (ctrl.slot == SLOT_W'(CELL_IDX));
  assign is_best = (best_idx == IDX_W'(CELL_IDX));

  // strict compares keep the earlier cell on a full tie
  assign own_better = valid &&
                      (!cand_in.found || (dyn_prio < cand_in.dyn) ||
                       ((dyn_prio == cand_in.dyn) && (insert_stamp < cand_in.stamp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_ADD:    if (hit) valid <= 1'b1;
        OP_REMOVE: if (hit) valid <= 1'b0;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_ADD: begin
        if (hit) begin
          static_prio  <= ctrl.prio;
          dyn_prio     <= DYN_W'(ctrl.prio);
          insert_stamp <= ctrl.stamp;
        end
      end
      OP_SETP: begin
        if (hit) begin
          static_prio <= ctrl.prio;
          dyn_prio    <= DYN_W'(ctrl.prio);
        end
      end
      OP_AGE: begin
        if (is_best) begin
          dyn_prio <= DYN_W'(static_prio);
        end else if (valid && (dyn_prio != DYN_FLOOR)) begin
          dyn_prio <= dyn_prio - DYN_W'(1);
        end
      end
      OP_NONE, OP_REMOVE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.found <= 1'b0;
    end else begin
      cand_out.found <= cand_in.found | valid;
    end
    if (own_better) begin
      cand_out.dyn   <= dyn_prio;
      cand_out.stamp <= insert_stamp;
      idx_out        <= IDX_W'(CELL_IDX);
    end else begin
      cand_out.dyn   <= cand_in.dyn;
      cand_out.stamp <= cand_in.stamp;
      idx_out        <= idx_in;
    end
  end

endmodule

>>> src/priority_scheduler_with_aging.sv
// top level of the priority scheduler with aging: command control and cell chain
// usage
//   s_* carries command items, m_* result items; one result per command, in order
//   s_tuser holds the command (add, remove, set priority, schedule), s_tdata
//   the slot index and the static priority of add and set priority
//   m_tdata holds the chosen slot (zero unless a schedule picked a task),
//   m_tuser the status (ok, slot used, slot empty, no task)
// timing
//   add, remove, set priority: the accepted command moves to the done state, which
//   loads the output register once it is free; m_tvalid rises as s_tready returns
//   schedule: the running best candidate walks the chain one registered cell per
//   cycle while the scan counter runs, then the done state loads the output register
//   as for the other commands; pick and aging happen in the same cycle
//   one command is in the block at a time; s_tready is high only when idle
// reset
//   rst (synchronous, active high) empties every slot, clears the insert stamp
//   counter and drops m_tvalid
// stalls
//   a result waits in the output register while m_tready is low; the next command
//   can still be taken, but its result is held until the output register frees up
module priority_scheduler_with_aging #(
  parameter int TASK_SLOTS = psa_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] slot_index, [9:4] priority_req, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] chosen_slot, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import psa_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  state_t state;
  state_t state_next;

  // captured command
  cmd_t                     cmd_q;
  logic [SLOT_W-1:0]        slot_q;
  logic signed [PRIO_W-1:0] prio_q;

  logic [IDX_W-1:0]   cnt;
  logic [STAMP_W-1:0] stamp_counter;

  // chain wiring, entry 0 feeds the first cell
  cand_t            cand_chain [TASK_SLOTS+1];
  logic [IDX_W-1:0] idx_chain  [TASK_SLOTS+1];
  logic [TASK_SLOTS-1:0] valid_vec;

  cell_ctrl_t ctrl;
  logic       in_accept;
  logic       out_free;
  logic       fire;
  logic       in_range;
  logic       cur_valid;
  logic [IDX_W-1:0] slot_idx;
  cell_op_t   op_sel;
  status_t    status_sel;
  logic [SLOT_W-1:0] chosen_sel;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // slot lookup for add, remove and set priority
  assign slot_idx  = IDX_W'(slot_q);
  assign in_range  = (32'(slot_q) < TASK_SLOTS);
  assign cur_valid = in_range && valid_vec[slot_idx];

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (cmd_t'(s_tuser) == CMD_SCHED) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(TASK_SLOTS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    s_tready   = (state == ST_IDLE);
    fire       = (state == ST_DONE) && out_free;
    op_sel     = OP_NONE;
    status_sel = STAT_OK;
    chosen_sel = '0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (cur_valid || !in_range) status_sel = STAT_USED;
        else                        op_sel     = OP_ADD;
      end
      CMD_REMOVE: begin
        if (cur_valid) op_sel     = OP_REMOVE;
        else           status_sel = STAT_EMPTY;
      end
      CMD_SETP: begin
        if (cur_valid) op_sel     = OP_SETP;
        else           status_sel = STAT_EMPTY;
      end
      CMD_SCHED: begin
        if (cand_chain[TASK_SLOTS].found) begin
          op_sel     = OP_AGE;
          chosen_sel = SLOT_W'(idx_chain[TASK_SLOTS]);
        end else begin
          status_sel = STAT_NO_TASK;
        end
      end
      default: ;
    endcase
    ctrl.op    = fire ? op_sel : OP_NONE;
    ctrl.slot  = slot_q;
    ctrl.prio  = prio_q;
    ctrl.stamp = stamp_counter;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= cmd_t'(s_tuser);
      slot_q <= s_tdata[3:0];
      prio_q <= s_tdata[9:4];
    end
  end

  // scan counter: one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_accept) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // insert stamp advances on every successful add, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
    end else if (ctrl.op == OP_ADD) begin
      stamp_counter <= stamp_counter + STAMP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'b0, chosen_sel};
      m_tuser <= status_sel;
    end
  end

  // ---------------------------------------------------------------- cell chain
  assign cand_chain[0] = '{found: 1'b0, dyn: '0, stamp: '0};
  assign idx_chain[0]  = '0;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    psa_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .best_idx (idx_chain[TASK_SLOTS]),
      .cand_in  (cand_chain[i]),
      .idx_in   (idx_chain[i]),
      .cand_out (cand_chain[i+1]),
      .idx_out  (idx_chain[i+1]),
      .valid    (valid_vec[i])
    );
  end

endmodule

>>> src/psa_checker.sv
// port-level checks for the priority scheduler with aging, bound to the top level
module psa_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);
  import psa_pkg::*;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");

  // one command at a time: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after accept");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // a failed command reports slot zero, padding stays zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == 8'd0))
    else $error("nonzero slot on failure");

  // a result only follows a command
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> !s_tready || $past(!s_tready))
    else $error("result without command");

endmodule

bind priority_scheduler_with_aging psa_checker u_psa_checker (.*);

>>> tb/sv/sched_checker.sv
`timescale 1ns / 100ps
// checker for the priority scheduler: shadow slot table, expected results and compare
module sched_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // [3:0] slot_index, [9:4] priority_req
  input  logic [1:0]  s_tuser,    // [1:0] cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [3:0] chosen_slot
  input  logic [1:0]  m_tuser,    // [1:0] status
  output int          fail_count,
  output int          pending,
  output int          n_results,
  output int          n_picks,
  output int          n_no_task
);
  import psa_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] chosen;
    status_t           status;
  } outcome_t;

  // shadow of the slot table
  logic                     slot_used [SLOT_SPAN];
  logic signed [PRIO_W-1:0] base_prio [SLOT_SPAN];
  logic signed [DYN_W-1:0]  aged_prio [SLOT_SPAN];
  logic [STAMP_W-1:0]       birth     [SLOT_SPAN];
  logic [STAMP_W-1:0]       next_birth;

  outcome_t outcome_q[$];
  int       fails = 0;

  assign fail_count = fails;

  // apply one command to the shadow table and return the result it gives
  function automatic outcome_t run_command(cmd_t cmd, logic [SLOT_W-1:0] slot,
                                           logic signed [PRIO_W-1:0] prio);
    outcome_t res;
    logic     hit;
    logic     found;
    int       best;
    logic signed [DYN_W-1:0] prio_wide;
    res.chosen = '0;
    res.status = STAT_OK;
    hit        = int'(slot) < TASK_SLOTS_DEF;
    prio_wide  = {{(DYN_W-PRIO_W){prio[PRIO_W-1]}}, prio};
    case (cmd)
      CMD_ADD: begin
        if (!hit || slot_used[slot]) begin
          res.status = STAT_USED;
        end else begin
          slot_used[slot] = 1'b1;
          base_prio[slot] = prio;
          aged_prio[slot] = prio_wide;
          birth[slot]     = next_birth;
          next_birth      = next_birth + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!hit || !slot_used[slot]) res.status = STAT_EMPTY;
        else slot_used[slot] = 1'b0;
      end
      CMD_SETP: begin
        if (!hit || !slot_used[slot]) begin
          res.status = STAT_EMPTY;
        end else begin
          base_prio[slot] = prio;
          aged_prio[slot] = prio_wide;
        end
      end
      CMD_SCHED: begin
        found = 1'b0;
        best  = 0;
        // lowest aged priority wins, ties to the older stamp, then the lower slot
        for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
          if (slot_used[i] && (!found || aged_prio[i] < aged_prio[best] ||
              (aged_prio[i] == aged_prio[best] && birth[i] < birth[best]))) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          res.status = STAT_NO_TASK;
        end else begin
          for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
            if (slot_used[i] && i != best && aged_prio[i] != DYN_FLOOR)
              aged_prio[i] = aged_prio[i] - 1'b1;
          end
          aged_prio[best] = {{(DYN_W-PRIO_W){base_prio[best][PRIO_W-1]}}, base_prio[best]};
          res.chosen      = SLOT_W'(best);
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    cmd_t     cmd;
    if (rst) begin
      for (int i = 0; i < SLOT_SPAN; i++) slot_used[i] = 1'b0;
      next_birth = '0;
      outcome_q.delete();
      pending   <= 0;
      n_results <= 0;
      n_picks   <= 0;
      n_no_task <= 0;
    end else begin
      // results first, so an item taken at this edge is not matched against them
      if (m_tvalid && m_tready) begin
        n_results <= n_results + 1;
        if (outcome_q.size() == 0) begin
          fails++;
          $error("result with nothing expected: chosen_slot %0d, status %0d",
                 m_tdata[3:0], m_tuser);
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata[3:0] !== want.chosen) begin
            fails++;
            $error("chosen_slot: expected %0d, got %0d", want.chosen, m_tdata[3:0]);
          end
          if (m_tuser !== want.status) begin
            fails++;
            $error("status: expected %0d, got %0d", want.status, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        cmd = cmd_t'(s_tuser);
        got = run_command(cmd, s_tdata[3:0], s_tdata[9:4]);
        outcome_q.push_back(got);
        if (cmd == CMD_SCHED && got.status == STAT_OK) n_picks <= n_picks + 1;
        if (got.status == STAT_NO_TASK) n_no_task <= n_no_task + 1;
      end
      pending <= outcome_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the priority scheduler: command stimulus, result stalls and verdict
module tb_top;
  import psa_pkg::*;

  localparam int ITEM_COUNT   = 1750;
  localparam int IDLE_LIMIT   = 2000;                 // cycles without any handshake on either side
  localparam int DRAIN_CYCLES = TASK_SLOTS_DEF + 8;   // one schedule pass plus margin

  localparam logic signed [PRIO_W-1:0] PRIO_LO = PRIO_W'(-32);
  localparam logic signed [PRIO_W-1:0] PRIO_HI = PRIO_W'(31);

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TRICKLE} rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;   // [3:0] slot_index, [9:4] priority_req, rest zero
  logic [1:0]  s_tuser  = '0;   // [1:0] cmd
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;         // [3:0] chosen_slot, rest zero
  logic [1:0]  m_tuser;         // [1:0] status

  int fail_count;
  int pending;
  int n_results;
  int n_picks;
  int n_no_task;

  // which slots the command stream has filled so far, to steer toward valid commands
  logic     table_used [SLOT_SPAN];
  int       burst_left  = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;

  priority_scheduler_with_aging #(
    .TASK_SLOTS (TASK_SLOTS_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sched_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_picks    (n_picks),
    .n_no_task  (n_no_task)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: stall modes that change every so often, including wide open stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_HALF:   m_tready <= $urandom_range(0, 1);
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // watchdog: a hung block shows up as a long run without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one command item and wait for it to be taken; bursts end in a random gap, which may be empty
  task automatic send_cmd(cmd_t cmd, logic [SLOT_W-1:0] slot, logic signed [PRIO_W-1:0] prio);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, prio, slot};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_ADD) table_used[slot] = 1'b1;
    else if (cmd == CMD_REMOVE) table_used[slot] = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // valid only drops when a real gap follows, never lowered and raised in one step
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int                       roll;
    int                       start;
    int                       idx;
    logic                     found;
    logic                     want_used;
    cmd_t                     cmd;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRIO_W-1:0] prio;

    for (int i = 0; i < SLOT_SPAN; i++) table_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part: empty table, used and empty slot errors, stamp ties, field extremes
    send_cmd(CMD_SCHED,  4'd0,  '0);        // nothing to schedule
    send_cmd(CMD_REMOVE, 4'd0,  '0);        // remove from an empty slot
    send_cmd(CMD_SETP,   4'd15, PRIO_HI);   // set priority on an empty slot
    send_cmd(CMD_ADD,    4'd0,  PRIO_LO);
    send_cmd(CMD_ADD,    4'd15, PRIO_HI);
    send_cmd(CMD_ADD,    4'd0,  '0);        // slot already used
    send_cmd(CMD_ADD,    4'd7,  PRIO_LO);   // ties slot 0, inserted later
    send_cmd(CMD_SCHED,  4'd0,  '0);        // older stamp wins the tie
    send_cmd(CMD_SCHED,  4'd0,  '0);        // the aged one now leads
    send_cmd(CMD_SETP,   4'd15, PRIO_LO);
    send_cmd(CMD_SCHED,  4'd0,  '0);
    send_cmd(CMD_SCHED,  4'd0,  '0);
    send_cmd(CMD_SETP,   4'd15, '0);
    send_cmd(CMD_REMOVE, 4'd7,  '0);
    send_cmd(CMD_REMOVE, 4'd7,  '0);        // already removed
    send_cmd(CMD_ADD,    4'd10, 6'sd5);
    send_cmd(CMD_ADD,    4'd5,  6'sd5);     // lower index but younger stamp
    send_cmd(CMD_SCHED,  4'd0,  '0);
    send_cmd(CMD_SCHED,  4'd0,  '0);
    send_cmd(CMD_REMOVE, 4'd0,  '0);
    send_cmd(CMD_REMOVE, 4'd5,  '0);
    send_cmd(CMD_REMOVE, 4'd10, '0);
    send_cmd(CMD_REMOVE, 4'd15, '0);
    send_cmd(CMD_SCHED,  4'd0,  '0);        // table empty again

    // random part: mostly commands that hit the right kind of slot, some noise
    for (int n = 0; n < ITEM_COUNT; n++) begin
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
        // now and then empty the whole table and schedule on it
        for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
          if (table_used[i]) send_cmd(CMD_REMOVE, SLOT_W'(i), PRIO_W'($urandom_range(0, 63)));
        end
        send_cmd(CMD_SCHED, SLOT_W'($urandom_range(0, 15)), PRIO_W'($urandom_range(0, 63)));
      end else begin
        if (roll < 38)      cmd = CMD_SCHED;
        else if (roll < 63) cmd = CMD_ADD;
        else if (roll < 78) cmd = CMD_REMOVE;
        else                cmd = CMD_SETP;

        // adds look for a free slot, remove and set priority for a filled one
        want_used = (cmd != CMD_ADD);
        slot      = SLOT_W'($urandom_range(0, 15));
        found     = 1'b0;
        start     = $urandom_range(0, 15);
        if ($urandom_range(0, 9) != 0) begin
          for (int k = 0; k < SLOT_SPAN; k++) begin
            idx = (start + k) % SLOT_SPAN;
            if (!found && table_used[idx] == want_used) begin
              slot  = SLOT_W'(idx);
              found = 1'b1;
            end
          end
        end

        // narrow priorities make equal aged values, and so stamp ties, common
        if ($urandom_range(0, 1) == 0) prio = PRIO_W'($urandom_range(0, 63));
        else prio = PRIO_W'(int'($urandom_range(0, 8)) - 4);

        send_cmd(cmd, slot, prio);
      end
    end
    s_tvalid <= 1'b0;

    // let every expected result arrive, then watch a while for stray ones
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d results checked, %0d schedules picked a task, %0d found none",
             n_results, n_picks, n_no_task);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> priority_scheduler_with_aging.f
src/psa_pkg.sv
src/psa_cell.sv
src/priority_scheduler_with_aging.sv
src/psa_checker.sv
tb/sv/sched_checker.sv
tb/sv/tb_top.sv
